FILE: rtl/scbc_pkg.sv
// Shared types and constants for the sparse cluster bitmask compressor.
package scbc_pkg;

    localparam int BYTE_W      = 8;
    localparam int BLOCK_BYTES = 8;
    localparam int BLOCK_W     = BLOCK_BYTES * BYTE_W;
    localparam int COUNT_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALARS_PER_CLUSTER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_CLUSTERS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_CLUSTERS   = 2'd2;

    typedef struct packed {
        logic [1:0] scalars_per_cluster;
        logic [3:0] window_clusters;
        logic [2:0] transfer_clusters;
    } cfg_t;

endpackage

FILE: rtl/scbc_front.sv
// Front end: collects scalars into the window and hands closed windows to the queue.
module scbc_front import scbc_pkg::*; #(
    parameter int CLUSTER_MAX = 2,
    parameter int WINDOW_MAX  = 8,
    parameter int ENTRY_W     = 1 + WINDOW_MAX + WINDOW_MAX * CLUSTER_MAX * BYTE_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  in_value,
    input  logic               in_eog,
    input  logic               in_eos,
    input  logic               q_full,
    output logic               push,
    output logic [ENTRY_W-1:0] push_entry
);

    localparam int BUF_DEPTH = WINDOW_MAX * CLUSTER_MAX;
    localparam int POS_W     = $clog2(BUF_DEPTH + 1);
    localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CMP_W     = (POS_W > 6) ? POS_W : 6;
    localparam int DATA_W    = BUF_DEPTH * BYTE_W;

    logic [BYTE_W-1:0] buf_reg [BUF_DEPTH];
    logic [BYTE_W-1:0] bufw    [BUF_DEPTH];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_inc;
    logic              pos_room;
    logic [5:0]        ws;
    logic              close;
    logic              acc;
    logic [DATA_W-1:0] win_data;
    logic [WINDOW_MAX-1:0] nz;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign pos_room = pos_reg < POS_W'(BUF_DEPTH);
    assign pos_inc  = pos_room ? pos_reg + POS_W'(1) : pos_reg;
    assign ws       = {2'b00, cfg.window_clusters} * {4'b0000, cfg.scalars_per_cluster};
    assign close    = (CMP_W'(pos_inc) >= CMP_W'(ws)) || in_eog || in_eos;
    assign push     = acc && close;
    assign pos_next = close ? '0 : pos_inc;

    // window as it stands once the incoming scalar is in place
    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            bufw[i] = (pos_room && pos_reg[IDX_W-1:0] == IDX_W'(i)) ? in_value : buf_reg[i];
        end
    end

    // regroup into clusters; scalars not yet received or beyond the window read as zero
    always_comb begin
        logic [BYTE_W-1:0] b;
        win_data = '0;
        nz       = '0;
        for (int c = 0; c < WINDOW_MAX; c++) begin
            for (int j = 0; j < CLUSTER_MAX; j++) begin
                b = '0;
                for (int k = 1; k <= CLUSTER_MAX; k++) begin
                    if (32'(cfg.scalars_per_cluster) == k && j < k
                        && c < 32'(cfg.window_clusters)
                        && (c * k + j) < 32'(pos_inc)) begin
                        b = bufw[c * k + j];
                    end
                end
                win_data[(c * CLUSTER_MAX + j) * BYTE_W +: BYTE_W] = b;
                if (b != '0) begin
                    nz[c] = 1'b1;
                end
            end
        end
    end

    assign push_entry = {in_eos, nz, win_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (acc) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && pos_room) begin
            buf_reg[pos_reg[IDX_W-1:0]] <= in_value;
        end
    end

endmodule

FILE: rtl/scbc_queue.sv
// Short queue of closed windows between front and back end.
module scbc_queue import scbc_pkg::*; #(
    parameter int WIDTH = 137
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = cnt_reg == '0;
    assign full    = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/scbc_back.sv
// Back end: emits the bitmask block and the packed data blocks of each window.
module scbc_back import scbc_pkg::*; #(
    parameter int CLUSTER_MAX  = 2,
    parameter int TRANSFER_MAX = 4,
    parameter int WINDOW_MAX   = 8,
    parameter int ENTRY_W      = 1 + WINDOW_MAX + WINDOW_MAX * CLUSTER_MAX * BYTE_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       q_empty,
    input  logic [ENTRY_W-1:0]         q_head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [BLOCK_W+COUNT_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [1:0]                 m_tuser
);

    localparam int DATA_W = WINDOW_MAX * CLUSTER_MAX * BYTE_W;
    localparam int SLOT_W = $clog2(WINDOW_MAX + 1);

    typedef enum logic [1:0] {
        PH_MASK = 2'b01,
        PH_DATA = 2'b10
    } phase_t;

    phase_t                phase_reg;
    logic [WINDOW_MAX-1:0] rem_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic                  valid_reg;
    logic [BLOCK_W-1:0]    block_reg;
    logic [COUNT_W-1:0]    bis_reg;
    logic                  isbm_reg;
    logic                  last_reg;
    logic                  done_reg;

    logic [DATA_W-1:0]     h_data;
    logic [WINDOW_MAX-1:0] h_mask;
    logic                  h_eos;
    logic                  fire;
    logic [BLOCK_W-1:0]    blk_mask;
    logic [BLOCK_W-1:0]    blk_data;
    logic [WINDOW_MAX-1:0] take;
    logic [WINDOW_MAX-1:0] rem_after;
    logic [SLOT_W-1:0]     slot [WINDOW_MAX];
    logic [BLOCK_W-1:0]    blk_next;
    logic                  is_mask;
    logic                  last_next;
    logic [COUNT_W-1:0]    cnt_inc;

    assign h_data  = q_head[DATA_W-1:0];
    assign h_mask  = q_head[DATA_W +: WINDOW_MAX];
    assign h_eos   = q_head[ENTRY_W-1];
    assign fire    = !q_empty && (!valid_reg || m_tready);
    assign cnt_inc = cnt_reg + COUNT_W'(1);

    always_comb begin
        blk_mask = '0;
        for (int i = 0; i < WINDOW_MAX && i < BLOCK_W; i++) begin
            blk_mask[i] = h_mask[i];
        end
    end

    // slot of each remaining nonzero cluster; take the first transfer_clusters of them
    always_comb begin
        logic [SLOT_W-1:0] run;
        run = '0;
        for (int c = 0; c < WINDOW_MAX; c++) begin
            slot[c] = run;
            take[c] = rem_reg[c] && (32'(run) < 32'(cfg.transfer_clusters));
            if (rem_reg[c]) begin
                run = run + SLOT_W'(1);
            end
        end
        rem_after = rem_reg & ~take;
    end

    always_comb begin
        blk_data = '0;
        for (int s = 0; s < TRANSFER_MAX; s++) begin
            for (int j = 0; j < CLUSTER_MAX; j++) begin
                if (s * CLUSTER_MAX + j < BLOCK_BYTES) begin
                    for (int c = 0; c < WINDOW_MAX; c++) begin
                        if (take[c] && 32'(slot[c]) == s) begin
                            blk_data[(s * CLUSTER_MAX + j) * BYTE_W +: BYTE_W] =
                                blk_data[(s * CLUSTER_MAX + j) * BYTE_W +: BYTE_W]
                                | h_data[(c * CLUSTER_MAX + j) * BYTE_W +: BYTE_W];
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_MASK: begin
                is_mask   = 1'b1;
                blk_next  = blk_mask;
                last_next = h_mask == '0;
            end
            PH_DATA: begin
                is_mask   = 1'b0;
                blk_next  = blk_data;
                last_next = rem_after == '0;
            end
            default: begin
                is_mask   = 1'b1;
                blk_next  = blk_mask;
                last_next = 1'b1;
            end
        endcase
    end

    assign pop = fire && last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MASK;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                valid_reg <= 1'b1;
                cnt_reg   <= (last_next && h_eos) ? '0 : cnt_inc;
                phase_reg <= last_next ? PH_MASK : PH_DATA;
                rem_reg   <= is_mask ? h_mask : rem_after;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            block_reg <= blk_next;
            bis_reg   <= cnt_inc;
            isbm_reg  <= is_mask;
            last_reg  <= last_next;
            done_reg  <= last_next && h_eos;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {bis_reg, block_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {done_reg, isbm_reg};

endmodule

FILE: rtl/sparse_cluster_bitmask_compressor.sv
// Top level of the sparse cluster bitmask compressor.
// Takes one scalar per cycle while the window queue has room; the back end emits one
// block per cycle while the queue holds a window and m_tready does not stall the output.
// A closing scalar's window goes into the queue, then its bitmask block is registered onto m_.
// Reset (aresetn low, synchronous) empties window, queue and output, clears the count.
module sparse_cluster_bitmask_compressor import scbc_pkg::*; #(
    parameter int CLUSTER_MAX  = 2,
    parameter int TRANSFER_MAX = 4,
    parameter int WINDOW_MAX   = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // scalar input
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic signed [BYTE_W-1:0]   s_tdata,   // [7:0] value
    input  logic                       s_tlast,   // end_of_group
    input  logic [0:0]                 s_tuser,   // [0] end_of_stream
    // transfer block output
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [BLOCK_W+COUNT_W-1:0] m_tdata,   // [63:0] block, [79:64] blocks_in_stream
    output logic                       m_tlast,   // last_of_run
    output logic [1:0]                 m_tuser,   // [0] is_bitmask, [1] stream_done
    // register writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int ENTRY_W = 1 + WINDOW_MAX + WINDOW_MAX * CLUSTER_MAX * BYTE_W;

    // register reset values, saturated to what the parameters allow
    localparam logic [1:0] CS_RESET = 2'((CLUSTER_MAX < 2) ? CLUSTER_MAX : 2);
    localparam logic [3:0] WC_RESET = 4'((WINDOW_MAX < 8) ? WINDOW_MAX : 8);
    localparam logic [2:0] TC_RESET = 3'((TRANSFER_MAX < 4) ? TRANSFER_MAX : 4);

    cfg_t               cfg_reg;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_head;
    logic [1:0]         cs_w;
    logic [3:0]         wc_w;
    logic [2:0]         tc_w;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // saturate written values into the legal range
    always_comb begin
        cs_w = cfg_data[1:0];
        if (cs_w == '0) begin
            cs_w = 2'd1;
        end else if (32'(cs_w) > CLUSTER_MAX) begin
            cs_w = 2'(CLUSTER_MAX);
        end
        wc_w = cfg_data[3:0];
        if (wc_w == '0) begin
            wc_w = 4'd1;
        end else if (32'(wc_w) > WINDOW_MAX) begin
            wc_w = 4'(WINDOW_MAX);
        end
        tc_w = cfg_data[2:0];
        if (tc_w == '0) begin
            tc_w = 3'd1;
        end else if (32'(tc_w) > TRANSFER_MAX) begin
            tc_w = 3'(TRANSFER_MAX);
        end
    end

    // drop writes to indexes beyond the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scalars_per_cluster <= CS_RESET;
            cfg_reg.window_clusters     <= WC_RESET;
            cfg_reg.transfer_clusters   <= TC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SCALARS_PER_CLUSTER: cfg_reg.scalars_per_cluster <= cs_w;
                CFG_WINDOW_CLUSTERS:     cfg_reg.window_clusters     <= wc_w;
                CFG_TRANSFER_CLUSTERS:   cfg_reg.transfer_clusters   <= tc_w;
                default: ;
            endcase
        end
    end

    // front: fill the window, close it, regroup into clusters and flag nonzero ones
    scbc_front #(
        .CLUSTER_MAX (CLUSTER_MAX),
        .WINDOW_MAX  (WINDOW_MAX),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata),
        .in_eog     (s_tlast),
        .in_eos     (s_tuser[0]),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_in)
    );

    // hold closed windows so the front keeps taking scalars while blocks drain
    scbc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back: emit bitmask block, then packed data blocks, one per cycle while m_tready allows
    scbc_back #(
        .CLUSTER_MAX  (CLUSTER_MAX),
        .TRANSFER_MAX (TRANSFER_MAX),
        .WINDOW_MAX   (WINDOW_MAX),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sim/tb_sparse_cluster_bitmask_compressor.sv
// Self-checking testbench for the sparse cluster bitmask compressor.
module tb_sparse_cluster_bitmask_compressor;
    import scbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLUSTER_MAX  = 2;
    localparam int TRANSFER_MAX = 4;
    localparam int WINDOW_MAX   = 8;
    localparam int BUF_DEPTH    = WINDOW_MAX * CLUSTER_MAX;
    localparam int MAX_BLOCKS   = WINDOW_MAX + 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;  // not a register

    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int TOTAL_SCALARS = 410;
    localparam int IDLE_LIMIT = 4000;     // cycles with no handshake at all

    // One scalar as offered on the s_ side.
    typedef struct {
        logic [BYTE_W-1:0] value;
        bit                eog;
        bit                eos;
    } scalar_t;

    // One transfer block as expected on the m_ side.
    typedef struct {
        logic [BLOCK_W-1:0] data;
        bit                 is_bitmask;
        bit                 last_of_run;
        logic [COUNT_W-1:0] count;
        bit                 stream_done;
    } xfer_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic signed [BYTE_W-1:0]   s_tdata = '0;    // [7:0] value
    logic                       s_tlast = 1'b0;  // end_of_group
    logic [0:0]                 s_tuser = '0;    // [0] end_of_stream
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [BLOCK_W+COUNT_W-1:0] m_tdata;         // [63:0] block, [79:64] blocks_in_stream
    logic                       m_tlast;         // last_of_run
    logic [1:0]                 m_tuser;         // [0] is_bitmask, [1] stream_done
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    sparse_cluster_bitmask_compressor #(
        .CLUSTER_MAX  (CLUSTER_MAX),
        .TRANSFER_MAX (TRANSFER_MAX),
        .WINDOW_MAX   (WINDOW_MAX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pending scalars for the driver, and blocks the compressor still owes us.
    scalar_t scalar_queue[$];
    xfer_t   due_blocks[$];

    // Mirror of the compressor: window contents, fill level, stream count, settings.
    logic [BYTE_W-1:0]  win_buf [BUF_DEPTH];
    int unsigned        fill_pos;
    logic [COUNT_W-1:0] stream_count;
    int unsigned        cluster_len;
    int unsigned        window_len;
    int unsigned        pack_len;

    // Random idling bounds, changed per phase; zero gives back-to-back traffic.
    int unsigned src_gap_max = 0;
    int unsigned sink_stall_max = 0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;

    int unsigned scalars_sent = 0;
    int unsigned blocks_checked = 0;
    int unsigned windows_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    scalar_t     fetched;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Apply a register write to the mirror; out-of-range values saturate, spare index is ignored.
    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SCALARS_PER_CLUSTER: cluster_len = clamp(int'(data[1:0]), 1, CLUSTER_MAX);
            CFG_WINDOW_CLUSTERS:     window_len  = clamp(int'(data), 1, WINDOW_MAX);
            CFG_TRANSFER_CLUSTERS:   pack_len    = clamp(int'(data[2:0]), 1, TRANSFER_MAX);
            default: ;
        endcase
    endfunction

    function automatic bit cluster_live(int unsigned c);
        for (int unsigned j = 0; j < cluster_len; j++) begin
            if (c * cluster_len + j < BUF_DEPTH && win_buf[c * cluster_len + j] != '0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Take one scalar into the mirror and queue every block its window close produces.
    function automatic void compress_scalar(logic [BYTE_W-1:0] v, bit eog, bit eos);
        xfer_t              outs [MAX_BLOCKS];
        int unsigned        n = 0;
        int unsigned        span = window_len * cluster_len;
        int unsigned        live = 0;
        int unsigned        slot = 0;
        int unsigned        b;
        int unsigned        idx;
        logic [BLOCK_W-1:0] mask = '0;
        logic [BLOCK_W-1:0] packed_blk = '0;

        if (fill_pos < BUF_DEPTH) begin
            win_buf[fill_pos] = v;
            fill_pos++;
        end
        if (!(fill_pos >= span || eog || eos)) return;

        // Pad missing scalars with zero and drop anything past a shrunk window.
        for (int unsigned i = 0; i < BUF_DEPTH; i++)
            if (i >= fill_pos || i >= span) win_buf[i] = '0;

        for (int unsigned c = 0; c < window_len; c++) begin
            if (cluster_live(c)) begin
                mask[c] = 1'b1;
                live++;
            end
        end
        stream_count++;
        outs[n] = '{mask, 1'b1, live == 0, stream_count, 1'b0};
        n++;

        for (int unsigned c = 0; c < window_len; c++) begin
            if (cluster_live(c)) begin
                for (int unsigned j = 0; j < cluster_len; j++) begin
                    b = slot * CLUSTER_MAX + j;
                    idx = c * cluster_len + j;
                    if (b < BLOCK_BYTES && idx < BUF_DEPTH)
                        packed_blk[8*b +: 8] = win_buf[idx];
                end
                slot++;
                live--;
            end
            if (slot >= pack_len || (c + 1 == window_len && slot > 0)) begin
                stream_count++;
                outs[n] = '{packed_blk, 1'b0, live == 0, stream_count, 1'b0};
                n++;
                packed_blk = '0;
                slot = 0;
            end
        end

        for (int unsigned i = 0; i < BUF_DEPTH; i++) win_buf[i] = '0;
        fill_pos = 0;
        if (eos) begin
            outs[n-1].stream_done = 1'b1;
            stream_count = '0;
        end
        for (int unsigned k = 0; k < n; k++) due_blocks = {due_blocks, outs[k]};
    endfunction

    // Driver: offer queued scalars, holding each until taken, with a random gap after each one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                compress_scalar(s_tdata, s_tlast, s_tuser[0]);
                scalars_sent++;
                src_wait = $urandom_range(0, src_gap_max);
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (scalar_queue.size() != 0) begin
                    fetched = scalar_queue.pop_front();
                    s_tdata  <= fetched.value;
                    s_tlast  <= fetched.eog;
                    s_tuser  <= fetched.eos;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted block against the oldest one owed, then stall at random.
    always @(posedge aclk) begin
        xfer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_blocks.size() == 0) begin
                    $display("%0t: unexpected block: expected none, got data=%h count=%0d",
                             $time, m_tdata[BLOCK_W-1:0], m_tdata[BLOCK_W +: COUNT_W]);
                    mismatches++;
                end else begin
                    want = due_blocks.pop_front();
                    if (m_tdata[BLOCK_W-1:0] !== want.data) begin
                        $display("%0t: block data: expected %h, got %h",
                                 $time, want.data, m_tdata[BLOCK_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[BLOCK_W +: COUNT_W] !== want.count) begin
                        $display("%0t: blocks_in_stream: expected %0d, got %0d",
                                 $time, want.count, m_tdata[BLOCK_W +: COUNT_W]);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.is_bitmask) begin
                        $display("%0t: is_bitmask: expected %0b, got %0b",
                                 $time, want.is_bitmask, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== want.stream_done) begin
                        $display("%0t: stream_done: expected %0b, got %0b",
                                 $time, want.stream_done, m_tuser[1]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last_of_run) begin
                        $display("%0t: last_of_run: expected %0b, got %0b",
                                 $time, want.last_of_run, m_tlast);
                        mismatches++;
                    end
                    if (want.is_bitmask) windows_seen++;
                end
                blocks_checked++;
                sink_wait = $urandom_range(0, sink_stall_max);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d blocks still owed",
                         $time, IDLE_LIMIT, due_blocks.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic void queue_scalar(logic [BYTE_W-1:0] v, bit eog, bit eos);
        scalar_t item;
        item = '{v, eog, eos};
        scalar_queue = {scalar_queue, item};
    endfunction

    // Mostly zeros so that whole clusters go empty; extremes now and then.
    function automatic logic [BYTE_W-1:0] draw_scalar();
        int unsigned pick = $urandom_range(0, 9);
        if (pick < 5) return '0;
        if (pick == 5) return 8'h7F;
        if (pick == 6) return 8'h80;
        return BYTE_W'($urandom);
    endfunction

    // Hold until the driver has nothing left and every owed block has come, then let it settle.
    task automatic wait_quiet();
        while (scalar_queue.size() != 0 || s_tvalid || due_blocks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned len;
        int unsigned phase;
        bit          eog;

        phase = 0;
        for (int unsigned i = 0; i < BUF_DEPTH; i++) win_buf[i] = '0;
        fill_pos     = 0;
        stream_count = '0;
        cluster_len  = 2;
        window_len   = 8;
        pack_len     = 4;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset settings: a full window with extreme values and empty clusters,
        // an all-zero window closed by group end, and a stream end without group end.
        queue_scalar(8'h7F, 0, 0); queue_scalar(8'h80, 0, 0);
        queue_scalar(8'h00, 0, 0); queue_scalar(8'h00, 0, 0);
        queue_scalar(8'h01, 0, 0); queue_scalar(8'h00, 0, 0);
        queue_scalar(8'h00, 0, 0); queue_scalar(8'h00, 0, 0);
        queue_scalar(8'h00, 0, 0); queue_scalar(8'hFF, 0, 0);
        queue_scalar(8'h05, 0, 0); queue_scalar(8'h06, 0, 0);
        queue_scalar(8'h00, 0, 0); queue_scalar(8'h00, 0, 0);
        queue_scalar(8'h00, 0, 0); queue_scalar(8'h55, 0, 0);
        queue_scalar(8'h00, 1, 0);
        queue_scalar(8'h03, 0, 1);
        // Leave a partial window of three scalars behind.
        queue_scalar(8'h07, 0, 0); queue_scalar(8'h00, 0, 0); queue_scalar(8'h09, 0, 0);
        wait_quiet();

        // Shrink the window below what is held: the next scalar closes it, the excess drops.
        write_reg(CFG_WINDOW_CLUSTERS, 4'd1);
        queue_scalar(8'hAA, 0, 0);
        wait_quiet();

        // Out-of-range writes saturate; the spare index must change nothing.
        write_reg(CFG_SCALARS_PER_CLUSTER, 4'hC);
        write_reg(CFG_WINDOW_CLUSTERS, 4'hF);
        write_reg(CFG_TRANSFER_CLUSTERS, 4'h0);
        write_reg(CFG_SPARE_INDEX, 4'h5);
        queue_scalar(8'h11, 0, 0); queue_scalar(8'h00, 0, 0);
        queue_scalar(8'h00, 0, 0); queue_scalar(8'h80, 1, 1);
        wait_quiet();

        // Random phases: fresh settings, fresh idling, a burst of scalars, then drain.
        while (scalars_sent + scalar_queue.size() < TOTAL_SCALARS) begin
            case (phase % 4)
                0: begin
                    write_reg(CFG_SCALARS_PER_CLUSTER, 4'd1);
                    write_reg(CFG_WINDOW_CLUSTERS, 4'd1);
                    write_reg(CFG_TRANSFER_CLUSTERS, 4'd1);
                end
                2: begin
                    write_reg(CFG_SCALARS_PER_CLUSTER, 4'd2);
                    write_reg(CFG_WINDOW_CLUSTERS, 4'd8);
                    write_reg(CFG_TRANSFER_CLUSTERS, 4'd4);
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        write_reg(CFG_INDEX_W'($urandom), CFG_DATA_W'($urandom));
                end
            endcase
            src_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 7;
            sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;

            len = $urandom_range(10, 50);
            for (int unsigned k = 0; k < len; k++) begin
                eog = ($urandom_range(0, 7) == 0);
                queue_scalar(draw_scalar(), eog, $urandom_range(0, 23) == 0);
            end
            wait_quiet();
            phase++;
        end

        wait_quiet();
        $display("Covered %0d scalars over %0d register writes and %0d random phases.",
                 scalars_sent, reg_writes, phase);
        $display("Checked %0d transfer blocks from %0d closed windows, %0d mismatches.",
                 blocks_checked, windows_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/scbc_pkg.sv
rtl/scbc_front.sv
rtl/scbc_queue.sv
rtl/scbc_back.sv
rtl/sparse_cluster_bitmask_compressor.sv
sim/tb_sparse_cluster_bitmask_compressor.sv
